// File: hdl/sgb_pkg.sv
package sgb_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int TAP_BITS    = 16;
	localparam int FRAC_BITS   = 15;
	localparam int ACC_W       = 40;
	localparam int PROD_W      = TAP_BITS + 1 + SAMPLE_BITS;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} sgb_op_t;

	typedef enum logic [2:0] {
		REG_HTAPS_LO = 3'd0,
		REG_HTAPS_HI = 3'd1,
		REG_VTAPS_LO = 3'd2,
		REG_VTAPS_HI = 3'd3,
		REG_HRADIUS  = 3'd4,
		REG_VRADIUS  = 3'd5,
		REG_COLUMNS  = 3'd6,
		REG_ROWS     = 3'd7
	} sgb_reg_t;

	// one step of the kernel walk as seen by a lane
	typedef struct packed {
		logic valid;
		logic h_first;
		logic h_last;
		logic v_first;
		logic v_last;
	} sgb_step_t;

	typedef struct packed {
		sgb_step_t  step;
		logic [2:0] h_k;
		logic [2:0] v_k;
	} sgb_issue_t;

	typedef struct packed {
		logic load;
		logic last;
	} sgb_emit_t;

	function automatic logic [TAP_BITS-1:0] tap_of(input logic [63:0] lo,
			input logic [63:0] hi, input logic [2:0] k);
		logic [63:0] w;
		w = k[2] ? hi : lo;
		return w[TAP_BITS*k[1:0] +: TAP_BITS];
	endfunction

	// add one half, floor shift, saturate to the sample format
	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
			input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] q;
		v = acc + ROUND_HALF;
		q = v >>> FRAC_BITS;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return SAMPLE_BITS'(q);
	endfunction

endpackage

// File: hdl/sgb_lane.sv
module sgb_lane import sgb_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sgb_step_t                     step,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [TAP_BITS-1:0]           htap,
	input  logic [TAP_BITS-1:0]           vtap,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	sgb_step_t                    ctl_s1;
	logic signed [PROD_W-1:0]     prod_h_s1;
	logic [TAP_BITS-1:0]          vtap_s1;

	logic signed [ACC_W-1:0]      hacc_s2;
	logic                         hdone_s2;
	logic [TAP_BITS-1:0]          vtap_s2;
	logic                         vf_s2;
	logic                         vl_s2;

	logic signed [SAMPLE_BITS-1:0] hmid_s3;
	logic                         hv_s3;
	logic [TAP_BITS-1:0]          vtap_s3;
	logic                         vf_s3;
	logic                         vl_s3;

	logic signed [PROD_W-1:0]     prod_v_s4;
	logic                         pv_s4;
	logic                         vf_s4;
	logic                         vl_s4;

	logic signed [ACC_W-1:0]      vacc_s5;
	logic                         vdone_s5;

	logic signed [SAMPLE_BITS-1:0] result_s6;
	logic                         done_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			hdone_s2 <= 1'b0;
			hv_s3    <= 1'b0;
			pv_s4    <= 1'b0;
			vdone_s5 <= 1'b0;
			done_s6  <= 1'b0;
		end else begin
			ctl_s1   <= step;
			hdone_s2 <= ctl_s1.valid && ctl_s1.h_last;
			hv_s3    <= hdone_s2;
			pv_s4    <= hv_s3;
			vdone_s5 <= pv_s4 && vl_s4;
			done_s6  <= vdone_s5;
		end
	end

	always_ff @(posedge clk) begin
		// horizontal multiply-accumulate
		prod_h_s1 <= signed'({1'b0, htap}) * sample;
		vtap_s1   <= vtap;
		if (ctl_s1.valid) begin
			hacc_s2 <= ctl_s1.h_first ? ACC_W'(prod_h_s1) : hacc_s2 + ACC_W'(prod_h_s1);
		end
		if (ctl_s1.valid && ctl_s1.h_last) begin
			vtap_s2 <= vtap_s1;
			vf_s2   <= ctl_s1.v_first;
			vl_s2   <= ctl_s1.v_last;
		end
		// intermediate back to sample format
		if (hdone_s2) begin
			hmid_s3 <= round_sat(hacc_s2);
			vtap_s3 <= vtap_s2;
			vf_s3   <= vf_s2;
			vl_s3   <= vl_s2;
		end
		// vertical multiply-accumulate
		if (hv_s3) begin
			prod_v_s4 <= signed'({1'b0, vtap_s3}) * hmid_s3;
			vf_s4     <= vf_s3;
			vl_s4     <= vl_s3;
		end
		if (pv_s4) begin
			vacc_s5 <= vf_s4 ? ACC_W'(prod_v_s4) : vacc_s5 + ACC_W'(prod_v_s4);
		end
		if (vdone_s5) begin
			result_s6 <= round_sat(vacc_s5);
		end
	end

	assign done   = done_s6;
	assign result = result_s6;

endmodule

// File: hdl/sgb_ctrl.sv
module sgb_ctrl import sgb_pkg::*; #(
	parameter  int MAX_COLUMNS = 64,
	parameter  int MAX_ROWS    = 64,
	parameter  int MAX_RADIUS  = 7,
	localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS,
	localparam int POS_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CI_W        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int RI_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             opcode,
	output logic             in_ready,
	input  logic [6:0]       frame_columns,
	input  logic [6:0]       frame_rows,
	input  logic [2:0]       horiz_radius,
	input  logic [2:0]       vert_radius,
	input  logic             lane_done,
	input  logic             out_free,
	output logic             wr_en,
	output logic [POS_W-1:0] wr_addr,
	output sgb_issue_t       issue_s2,
	output logic [POS_W-1:0] rd_addr_s2,
	output sgb_emit_t        emit,
	output logic [CI_W-1:0]  pixel_col,
	output logic [RI_W-1:0]  pixel_row
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int COL_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int CS_W  = ((CI_W > 3) ? CI_W : 3) + 2;
	localparam int RS_W  = ((RI_W > 3) ? RI_W : 3) + 2;
	localparam int DC_W  = $clog2(POS_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN,
		ST_DRAIN,
		ST_PUT
	} state_t;

	state_t                   state_q;
	logic [POS_W-1:0]         load_pos_q;
	logic [POS_W-1:0]         emit_pos_q;
	logic                     last_q;
	logic [DC_W-1:0]          div_cnt_q;
	logic [COL_W:0]           rem_q;
	logic [POS_W-1:0]         quot_q;
	logic [CI_W-1:0]          col_q;
	logic [RI_W-1:0]          row_q;
	logic signed [3:0]        h_off_q;
	logic signed [3:0]        v_off_q;

	logic [COL_W-1:0]         cols;
	logic [ROW_W-1:0]         rows;
	logic [2:0]               hr;
	logic [2:0]               vr;
	logic signed [3:0]        hr_s;
	logic signed [3:0]        vr_s;
	logic [COL_W+ROW_W-1:0]   area;
	logic [CNT_W-1:0]         count;

	logic [POS_W-1:0]         load_cur;
	logic [POS_W-1:0]         load_nxt;
	logic [CNT_W-1:0]         load_inc;
	logic [POS_W-1:0]         emit_cur;
	logic [POS_W-1:0]         emit_nxt;
	logic [CNT_W-1:0]         emit_inc;

	logic [COL_W:0]           rem_sh;
	logic [COL_W:0]           rem_nxt;
	logic [POS_W-1:0]         quot_nxt;

	logic signed [CS_W-1:0]   csum;
	logic signed [CS_W-1:0]   cmax;
	logic signed [RS_W-1:0]   rsum;
	logic signed [RS_W-1:0]   rmax;
	logic [CI_W-1:0]          c_cl;
	logic [RI_W-1:0]          r_cl;
	sgb_issue_t               issue;

	sgb_issue_t               issue_s1;
	logic [CI_W-1:0]          c_s1;
	logic [RI_W-1:0]          r_s1;
	logic [RI_W+COL_W:0]      addr_full;

	// frame geometry
	always_comb begin
		if (frame_columns == 7'd0) begin
			cols = COL_W'(1);
		end else if (32'(frame_columns) > MAX_COLUMNS) begin
			cols = COL_W'(MAX_COLUMNS);
		end else begin
			cols = COL_W'(frame_columns);
		end
		if (frame_rows == 7'd0) begin
			rows = ROW_W'(1);
		end else if (32'(frame_rows) > MAX_ROWS) begin
			rows = ROW_W'(MAX_ROWS);
		end else begin
			rows = ROW_W'(frame_rows);
		end
		hr = horiz_radius;
		if (32'(hr) > MAX_RADIUS) begin
			hr = 3'(MAX_RADIUS);
		end
		if (32'(hr) > 32'(cols) - 32'd1) begin
			hr = 3'(32'(cols) - 32'd1);
		end
		vr = vert_radius;
		if (32'(vr) > MAX_RADIUS) begin
			vr = 3'(MAX_RADIUS);
		end
		if (32'(vr) > 32'(rows) - 32'd1) begin
			vr = 3'(32'(rows) - 32'd1);
		end
		hr_s  = signed'({1'b0, hr});
		vr_s  = signed'({1'b0, vr});
		area  = cols * rows;
		count = CNT_W'(area);
	end

	// raster positions, restarting when past the frame end
	always_comb begin
		load_cur = (CNT_W'(load_pos_q) >= count) ? '0 : load_pos_q;
		load_inc = CNT_W'(load_cur) + CNT_W'(1);
		load_nxt = (load_inc >= count) ? '0 : POS_W'(load_inc);
		emit_cur = (CNT_W'(emit_pos_q) >= count) ? '0 : emit_pos_q;
		emit_inc = CNT_W'(emit_cur) + CNT_W'(1);
		emit_nxt = (emit_inc >= count) ? '0 : POS_W'(emit_inc);
	end

	// one quotient bit a cycle
	always_comb begin
		rem_sh = {rem_q[COL_W-1:0], quot_q[POS_W-1]};
		if (rem_sh >= {1'b0, cols}) begin
			rem_nxt  = rem_sh - {1'b0, cols};
			quot_nxt = {quot_q[POS_W-2:0], 1'b1};
		end else begin
			rem_nxt  = rem_sh;
			quot_nxt = {quot_q[POS_W-2:0], 1'b0};
		end
	end

	// clamp-to-edge sample position for the current offsets
	always_comb begin
		csum = CS_W'(signed'({1'b0, col_q})) + CS_W'(h_off_q);
		cmax = CS_W'(signed'({1'b0, cols})) - CS_W'(1);
		rsum = RS_W'(signed'({1'b0, row_q})) + RS_W'(v_off_q);
		rmax = RS_W'(signed'({1'b0, rows})) - RS_W'(1);
		if (csum[CS_W-1]) begin
			c_cl = '0;
		end else if (csum > cmax) begin
			c_cl = CI_W'(cmax);
		end else begin
			c_cl = CI_W'(csum);
		end
		if (rsum[RS_W-1]) begin
			r_cl = '0;
		end else if (rsum > rmax) begin
			r_cl = RI_W'(rmax);
		end else begin
			r_cl = RI_W'(rsum);
		end
		issue.step.valid   = (state_q == ST_RUN);
		issue.step.h_first = (h_off_q == -hr_s);
		issue.step.h_last  = (h_off_q == hr_s);
		issue.step.v_first = (v_off_q == -vr_s);
		issue.step.v_last  = (v_off_q == vr_s);
		issue.h_k          = h_off_q[3] ? 3'(-h_off_q) : h_off_q[2:0];
		issue.v_k          = v_off_q[3] ? 3'(-v_off_q) : v_off_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			emit_pos_q <= '0;
			last_q     <= 1'b0;
			div_cnt_q  <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			h_off_q    <= '0;
			v_off_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_LOAD) begin
							load_pos_q <= load_nxt;
						end else begin
							emit_pos_q <= emit_nxt;
							last_q     <= (emit_inc == count);
							quot_q     <= emit_cur;
							rem_q      <= '0;
							div_cnt_q  <= DC_W'(POS_W);
							state_q    <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= rem_nxt;
					quot_q    <= quot_nxt;
					div_cnt_q <= div_cnt_q - DC_W'(1);
					if (div_cnt_q == DC_W'(1)) begin
						col_q   <= CI_W'(rem_nxt);
						row_q   <= RI_W'(quot_nxt);
						h_off_q <= -hr_s;
						v_off_q <= -vr_s;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (h_off_q == hr_s) begin
						h_off_q <= -hr_s;
						if (v_off_q == vr_s) begin
							state_q <= ST_DRAIN;
						end else begin
							v_off_q <= v_off_q + 4'sd1;
						end
					end else begin
						h_off_q <= h_off_q + 4'sd1;
					end
				end
				ST_DRAIN: begin
					if (lane_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// address pipeline into the frame store
	assign addr_full = r_s1 * cols + c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
			issue_s2 <= '0;
		end else begin
			issue_s1 <= issue;
			issue_s2 <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s1       <= c_cl;
		r_s1       <= r_cl;
		rd_addr_s2 <= POS_W'(addr_full);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign wr_en     = in_valid && in_ready && (opcode == OP_LOAD);
	assign wr_addr   = load_cur;
	assign emit.load = (state_q == ST_PUT) && out_free;
	assign emit.last = last_q;
	assign pixel_col = col_q;
	assign pixel_row = row_q;

	a_idle_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!issue_s1.step.valid && !issue_s2.step.valid))
		else $error("store read in flight while idle");

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) < count))
		else $error("load address beyond frame");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done |-> (state_q == ST_DRAIN))
		else $error("lane result outside drain");

endmodule

// File: hdl/separable_gaussian_blur_top.sv
// Separable Gaussian blur with clamp-to-edge borders over one frame of two-channel
// signed 16-bit samples. Load words (opcode 0) write the frame store in raster order;
// request words (opcode 1) return the next output pixel in raster order. For a request,
// a restoring division splits the position into row and column, then the kernel walk
// reads one stored word per cycle from the frame store, and that read feeds both channel
// lanes, each with one multiply-accumulate for the row pass and one for the column pass;
// the lanes then drain into the output register. Items are taken one at a time; a
// finished pixel sits in the output register while the next word is accepted. Taps are
// Q1.15, written pre-normalised; the store is not cleared, so load the frame before
// requests.
module separable_gaussian_blur_top import sgb_pkg::*; #(
	parameter  int MAX_COLUMNS = 64,
	parameter  int MAX_ROWS    = 64,
	parameter  int MAX_RADIUS  = 7,
	parameter  int CHANNELS    = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic signed [SAMPLE_BITS-1:0] sample_first,
	input  logic signed [SAMPLE_BITS-1:0] sample_second,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] blurred_first,
	output logic signed [SAMPLE_BITS-1:0] blurred_second,
	output logic [5:0]                    pixel_column,
	output logic [5:0]                    pixel_row,
	output logic                          frame_done,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [63:0]                   cfg_data
);

	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CI_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WORD_W = CHANNELS * SAMPLE_BITS;

	logic [63:0]             htaps_lo_q;
	logic [63:0]             htaps_hi_q;
	logic [63:0]             vtaps_lo_q;
	logic [63:0]             vtaps_hi_q;
	logic [2:0]              hradius_q;
	logic [2:0]              vradius_q;
	logic [6:0]              columns_q;
	logic [6:0]              rows_q;

	logic                    wr_en;
	logic [POS_W-1:0]        wr_addr;
	logic [WORD_W-1:0]       wr_word;
	sgb_issue_t              issue_s2;
	logic [POS_W-1:0]        rd_addr_s2;
	sgb_issue_t              issue_s3;
	logic [WORD_W-1:0]       rd_word_s3;
	sgb_emit_t               emit;
	logic [CI_W-1:0]         pixel_col;
	logic [RI_W-1:0]         pixel_row_idx;
	logic [31:0]             col_wide;
	logic [31:0]             row_wide;
	logic                    out_free;
	logic                    out_valid_q;

	logic [TAP_BITS-1:0]     htap;
	logic [TAP_BITS-1:0]     vtap;
	logic                    lane_done [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] lane_result [CHANNELS];

	logic [WORD_W-1:0]       store_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			htaps_lo_q <= 64'd32768;
			htaps_hi_q <= 64'd0;
			vtaps_lo_q <= 64'd32768;
			vtaps_hi_q <= 64'd0;
			hradius_q  <= 3'd0;
			vradius_q  <= 3'd0;
			columns_q  <= 7'd64;
			rows_q     <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HTAPS_LO: htaps_lo_q <= cfg_data;
				REG_HTAPS_HI: htaps_hi_q <= cfg_data;
				REG_VTAPS_LO: vtaps_lo_q <= cfg_data;
				REG_VTAPS_HI: vtaps_hi_q <= cfg_data;
				REG_HRADIUS:  hradius_q  <= cfg_data[2:0];
				REG_VRADIUS:  vradius_q  <= cfg_data[2:0];
				REG_COLUMNS:  columns_q  <= cfg_data[6:0];
				REG_ROWS:     rows_q     <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	sgb_ctrl #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.opcode       (opcode),
		.in_ready     (in_ready),
		.frame_columns(columns_q),
		.frame_rows   (rows_q),
		.horiz_radius (hradius_q),
		.vert_radius  (vradius_q),
		.lane_done    (lane_done[0]),
		.out_free     (out_free),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.issue_s2     (issue_s2),
		.rd_addr_s2   (rd_addr_s2),
		.emit         (emit),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row_idx)
	);

	// frame store word: first channel in the low half
	assign wr_word[SAMPLE_BITS-1:0] = sample_first;
	if (CHANNELS > 1) begin : g_second
		assign wr_word[WORD_W-1:SAMPLE_BITS] = sample_second;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_word;
		end
		if (issue_s2.step.valid) begin
			rd_word_s3 <= store_mem[rd_addr_s2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s3 <= '0;
		end else begin
			issue_s3 <= issue_s2;
		end
	end

	assign htap = tap_of(htaps_lo_q, htaps_hi_q, issue_s3.h_k);
	assign vtap = tap_of(vtaps_lo_q, vtaps_hi_q, issue_s3.v_k);

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		sgb_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (issue_s3.step),
			.sample(rd_word_s3[ch*SAMPLE_BITS +: SAMPLE_BITS]),
			.htap  (htap),
			.vtap  (vtap),
			.done  (lane_done[ch]),
			.result(lane_result[ch])
		);
	end

	// merge lane results into the output register
	assign out_free = !out_valid_q || out_ready;
	assign col_wide = 32'(pixel_col);
	assign row_wide = 32'(pixel_row_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			blurred_first  <= lane_result[0];
			blurred_second <= (CHANNELS > 1) ? lane_result[CHANNELS-1] : '0;
			pixel_column   <= col_wide[5:0];
			pixel_row      <= row_wide[5:0];
			frame_done     <= emit.last;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> (!out_valid_q || out_ready))
		else $error("pending output word overwritten");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit.load))
		else $error("output valid without a merged result");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import sgb_pkg::*;

	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int RANDOM_ITEMS = 950;
	localparam int TAIL_CYCLES  = 300;

	typedef struct packed {
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic [5:0]         column;
		logic [5:0]         row;
		logic               done;
	} pixel_t;

	typedef struct packed {
		logic        is_cfg;
		sgb_reg_t    idx;
		logic [63:0] data;
		sgb_op_t     op;
		logic [15:0] a;
		logic [15:0] b;
		pixel_t      want;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          opcode;
	logic signed [SAMPLE_BITS-1:0] sample_first;
	logic signed [SAMPLE_BITS-1:0] sample_second;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [SAMPLE_BITS-1:0] blurred_first;
	logic signed [SAMPLE_BITS-1:0] blurred_second;
	logic [5:0]                    pixel_column;
	logic [5:0]                    pixel_row;
	logic                          frame_done;
	logic                          cfg_we;
	logic [2:0]                    cfg_index;
	logic [63:0]                   cfg_data;

	separable_gaussian_blur_top dut (.*);

	// shadow copy of the block state
	logic [63:0]        hz_taps_lo, hz_taps_hi, vt_taps_lo, vt_taps_hi;
	logic [2:0]         hz_radius, vt_radius;
	logic [6:0]         cols_reg, rows_reg;
	logic signed [15:0] frame_copy [2][4096];
	int                 load_at, emit_at;

	pixel_t    expected_pixels [$];
	stim_row_t directed [$];
	int        errors, cycle_count, items_sent, loads_sent, pixels_asked, pixels_seen;
	int        settings_run;
	bit        calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_extent(input logic [6:0] v);
		if (v == 0)
			return 1;
		return (v > 64) ? 64 : int'(v);
	endfunction

	function automatic int fit_radius(input logic [2:0] r, input int extent);
		return (int'(r) > extent - 1) ? extent - 1 : int'(r);
	endfunction

	function automatic int clamp_to(input int i, input int extent);
		if (i < 0)
			return 0;
		return (i > extent - 1) ? extent - 1 : i;
	endfunction

	function automatic longint tap_weight(input logic [63:0] lo, input logic [63:0] hi,
			input int k);
		logic [63:0] w;
		w = (k < 4) ? lo : hi;
		return longint'(w[16*(k%4) +: 16]);
	endfunction

	// half up, floor shift, saturate
	function automatic logic signed [15:0] round_sat16(input longint acc);
		longint v;
		v = (acc + 64'sd16384) >>> 15;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic longint row_pass(input int row, input int col, input int ch,
			input int cols, input int hr);
		longint acc;
		int     o, c, k;
		acc = 0;
		for (o = -hr; o <= hr; o++) begin
			c = clamp_to(col + o, cols);
			k = (o < 0) ? -o : o;
			acc += tap_weight(hz_taps_lo, hz_taps_hi, k) *
				longint'(frame_copy[ch][(row * cols + c) % 4096]);
		end
		return longint'(round_sat16(acc));
	endfunction

	task automatic predict_word(input sgb_op_t op, input logic [15:0] a, input logic [15:0] b,
			output bit has, output pixel_t px);
		int                 cols, rows, count, col, row, hr, vr, ch, o, k;
		longint             acc;
		logic signed [15:0] lane [2];
		cols  = eff_extent(cols_reg);
		rows  = eff_extent(rows_reg);
		count = cols * rows;
		has   = 1'b0;
		px    = '0;
		if (op == OP_LOAD) begin
			if (load_at >= count)
				load_at = 0;
			frame_copy[0][load_at] = a;
			frame_copy[1][load_at] = b;
			load_at = (load_at + 1 >= count) ? 0 : load_at + 1;
		end else begin
			if (emit_at >= count)
				emit_at = 0;
			col = emit_at % cols;
			row = emit_at / cols;
			hr  = fit_radius(hz_radius, cols);
			vr  = fit_radius(vt_radius, rows);
			for (ch = 0; ch < 2; ch++) begin
				acc = 0;
				for (o = -vr; o <= vr; o++) begin
					k = (o < 0) ? -o : o;
					acc += tap_weight(vt_taps_lo, vt_taps_hi, k) *
						row_pass(clamp_to(row + o, rows), col, ch, cols, hr);
				end
				lane[ch] = round_sat16(acc);
			end
			has       = 1'b1;
			px.first  = lane[0];
			px.second = lane[1];
			px.column = 6'(col);
			px.row    = 6'(row);
			px.done   = (emit_at == count - 1);
			emit_at   = (emit_at + 1 >= count) ? 0 : emit_at + 1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("pixel %0d %s got %0d want %0d", pixels_seen, name, got,
				want));
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("unexpected pixel at column %0d row %0d", pixel_column,
				pixel_row));
			return;
		end
		want = expected_pixels.pop_front();
		check_field("blurred_first", int'(blurred_first), int'(want.first));
		check_field("blurred_second", int'(blurred_second), int'(want.second));
		check_field("pixel_column", int'(pixel_column), int'(want.column));
		check_field("pixel_row", int'(pixel_row), int'(want.row));
		check_field("frame_done", int'(frame_done), int'(want.done));
		pixels_seen++;
	endtask

	// result side: check, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_pixel();
		out_ready <= calm || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
				expected_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input sgb_op_t op, input logic [15:0] a, input logic [15:0] b,
			input bit typed, input pixel_t want);
		bit     has;
		pixel_t px;
		calm = (items_sent >= 400 && items_sent < 600);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		sample_first  <= a;
		sample_second <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_word(op, a, b, has, px);
		if (has)
			expected_pixels.push_back(typed ? want : px);
		items_sent++;
		if (op == OP_LOAD)
			loads_sent++;
		else
			pixels_asked++;
	endtask

	// wait for the block to go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input sgb_reg_t idx, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HTAPS_LO: hz_taps_lo = data;
			REG_HTAPS_HI: hz_taps_hi = data;
			REG_VTAPS_LO: vt_taps_lo = data;
			REG_VTAPS_HI: vt_taps_hi = data;
			REG_HRADIUS:  hz_radius  = data[2:0];
			REG_VRADIUS:  vt_radius  = data[2:0];
			REG_COLUMNS:  cols_reg   = data[6:0];
			REG_ROWS:     rows_reg   = data[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic void put_cfg(input sgb_reg_t idx, input logic [63:0] data);
		stim_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		directed.push_back(r);
	endfunction

	function automatic void put_load(input logic [15:0] a, input logic [15:0] b);
		stim_row_t r;
		r    = '0;
		r.op = OP_LOAD;
		r.a  = a;
		r.b  = b;
		directed.push_back(r);
	endfunction

	function automatic void put_emit(input logic [15:0] first, input logic [15:0] second,
			input int col, input int row, input logic done);
		stim_row_t r;
		r      = '0;
		r.op   = OP_EMIT;
		r.a    = 16'h8000;
		r.b    = 16'h7FFF;
		r.want = '{first, second, 6'(col), 6'(row), done};
		directed.push_back(r);
	endfunction

	function automatic logic [63:0] random_taps();
		logic [63:0] w;
		int          lane;
		for (lane = 0; lane < 4; lane++)
			case ($urandom_range(5))
				0: w[16*lane +: 16] = 16'($urandom);
				1: w[16*lane +: 16] = 16'h0000;
				2: w[16*lane +: 16] = 16'hFFFF;
				default: w[16*lane +: 16] = 16'($urandom_range(12000));
			endcase
		return w;
	endfunction

	function automatic logic [15:0] random_sample();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		return 16'($urandom);
	endfunction

	initial begin : stimulus
		int cols_w, rows_w, count, n_mix, i;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_LOAD;
		sample_first  = '0;
		sample_second = '0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_HTAPS_LO;
		cfg_data      = '0;
		hz_taps_lo    = 64'd32768;
		hz_taps_hi    = '0;
		vt_taps_lo    = 64'd32768;
		vt_taps_hi    = '0;
		hz_radius     = '0;
		vt_radius     = '0;
		cols_reg      = 7'd64;
		rows_reg      = 7'd64;
		load_at       = 0;
		emit_at       = 0;
		for (i = 0; i < 4096; i++) begin
			frame_copy[0][i] = '0;
			frame_copy[1][i] = '0;
		end

		// reset taps and radii give the identity on a 2 x 2 frame
		put_cfg(REG_COLUMNS, 64'd2);
		put_cfg(REG_ROWS, 64'd2);
		put_load(16'h7FFF, 16'h8000);
		put_load(16'h8000, 16'h7FFF);
		put_load(16'h0000, 16'hFFFF);
		put_load(16'h5555, 16'hAAAA);
		put_emit(16'h7FFF, 16'h8000, 0, 0, 1'b0);
		put_emit(16'h8000, 16'h7FFF, 1, 0, 1'b0);
		put_emit(16'h0000, 16'hFFFF, 0, 1, 1'b0);
		put_emit(16'h5555, 16'hAAAA, 1, 1, 1'b1);
		put_emit(16'h7FFF, 16'h8000, 0, 0, 1'b0);
		// full-scale taps, radius past the frame edge, both lanes saturate
		put_cfg(REG_HTAPS_LO, '1);
		put_cfg(REG_HTAPS_HI, '1);
		put_cfg(REG_VTAPS_LO, '1);
		put_cfg(REG_VTAPS_HI, '1);
		put_cfg(REG_HRADIUS, 64'd7);
		put_cfg(REG_VRADIUS, 64'd7);
		put_cfg(REG_COLUMNS, 64'd3);
		put_cfg(REG_ROWS, 64'd3);
		repeat (9) put_load(16'h7FFF, 16'h8000);
		put_emit(16'h7FFF, 16'h8000, 1, 0, 1'b0);
		put_emit(16'h7FFF, 16'h8000, 2, 0, 1'b0);
		// half weight on a single pixel, ties go upward
		put_cfg(REG_COLUMNS, 64'd1);
		put_cfg(REG_ROWS, 64'd1);
		put_cfg(REG_HTAPS_LO, 64'hFFFF_FFFF_FFFF_4000);
		put_cfg(REG_VTAPS_LO, 64'hFFFF_FFFF_FFFF_8000);
		put_load(16'h0001, 16'hFFFF);
		put_emit(16'h0001, 16'h0000, 0, 0, 1'b1);
		put_load(16'h0003, 16'hFFFD);
		put_emit(16'h0002, 16'hFFFF, 0, 0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				settle();
				write_reg(directed[i].idx, directed[i].data);
			end else begin
				send_word(directed[i].op, directed[i].a, directed[i].b, 1'b1, directed[i].want);
			end
		end
		settings_run = 3;

		count = items_sent + RANDOM_ITEMS;
		while (items_sent < count) begin
			case ($urandom_range(11))
				0: begin cols_w = 64;                     rows_w = $urandom_range(1, 2); end
				1: begin cols_w = $urandom_range(65, 127); rows_w = 1;                 end
				2: begin cols_w = 0;                      rows_w = $urandom_range(1, 8); end
				3: begin cols_w = 1;                      rows_w = 64;                   end
				4: begin
					cols_w = $urandom_range(1, 2);
					rows_w = $urandom_range(1) ? 0 : $urandom_range(65, 127);
				end
				default: begin cols_w = $urandom_range(1, 8); rows_w = $urandom_range(1, 8); end
			endcase
			settle();
			write_reg(REG_HTAPS_LO, random_taps());
			write_reg(REG_HTAPS_HI, random_taps());
			write_reg(REG_VTAPS_LO, random_taps());
			write_reg(REG_VTAPS_HI, random_taps());
			write_reg(REG_HRADIUS, (64'($urandom) << 3) | 64'($urandom_range(7)));
			write_reg(REG_VRADIUS, (64'($urandom) << 3) | 64'($urandom_range(7)));
			write_reg(REG_COLUMNS, (64'($urandom) << 7) | 64'(cols_w));
			write_reg(REG_ROWS, (64'($urandom) << 7) | 64'(rows_w));
			settings_run++;
			repeat (eff_extent(7'(cols_w)) * eff_extent(7'(rows_w)))
				send_word(OP_LOAD, random_sample(), random_sample(), 1'b0, '0);
			n_mix = $urandom_range(4, 40);
			repeat (n_mix)
				send_word(($urandom_range(4) == 0) ? OP_LOAD : OP_EMIT, random_sample(),
					random_sample(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
		$display("covered %0d load words and %0d pixel requests over %0d frame settings",
			loads_sent, pixels_asked, settings_run);
		$display("%0d pixels checked in %0d cycles, %0d mismatches", pixels_seen, cycle_count,
			errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
